// File: rtl/core/cllc_pkg.sv
`timescale 1ns / 1ps

package cllc_pkg;

  // Request codes carried on req_type.
  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_ADVANCE = 2'd1;
  localparam logic [1:0] REQ_REMOVE  = 2'd2;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_FIN,
    ST_DONE
  } state_e;

  // Free-pool control: take one index, or give one back.
  typedef struct packed {
    logic pop;
    logic push;
  } free_ctrl_t;

endpackage

// File: rtl/core/cllc_ram.sv
`timescale 1ns / 1ps

module cllc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/cllc_free_pool.sv
`timescale 1ns / 1ps

module cllc_free_pool
  import cllc_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = $clog2(DEPTH),
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  free_ctrl_t       ctrl_i,
  input  logic [IDX_W-1:0] push_idx_i,
  output logic [IDX_W-1:0] alloc_idx_o
);

  // Indices never handed out come from a fill counter; returned ones sit on a stack.
  logic [CNT_W-1:0] rec_cnt_q, rec_cnt_d;
  logic [CNT_W-1:0] fresh_q, fresh_d;
  logic [CNT_W-1:0] top_m1;
  logic [IDX_W-1:0] stack_rdata;

  assign top_m1 = rec_cnt_q - CNT_W'(1);

  cllc_ram #(
    .WIDTH (IDX_W),
    .DEPTH (DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.push),
    .waddr_i (rec_cnt_q[IDX_W-1:0]),
    .wdata_i (push_idx_i),
    .raddr_i (top_m1[IDX_W-1:0]),
    .rdata_o (stack_rdata)
  );

  assign alloc_idx_o = (rec_cnt_q != '0) ? stack_rdata : fresh_q[IDX_W-1:0];

  always_comb begin
    rec_cnt_d = rec_cnt_q;
    fresh_d   = fresh_q;
    if (ctrl_i.push) begin
      rec_cnt_d = rec_cnt_q + CNT_W'(1);
    end else if (ctrl_i.pop) begin
      if (rec_cnt_q != '0) begin
        rec_cnt_d = top_m1;
      end else begin
        fresh_d = fresh_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_cnt_q <= '0;
      fresh_q   <= '0;
    end else begin
      rec_cnt_q <= rec_cnt_d;
      fresh_q   <= fresh_d;
    end
  end

endmodule

// File: rtl/core/circular_list_with_cursor_unit.sv
`timescale 1ns / 1ps

// Circular singly linked list of up to DEPTH signed 32-bit values with a cursor.
// Nodes live in a value RAM and a next-link RAM (one write and one registered
// read port each); free entries come from a pool of never-used indices plus a
// RAM stack of returned ones. A predecessor register tracks the node linking to
// the cursor, so remove needs no ring walk. Each item is insert (value goes
// after the cursor and becomes the cursor; refused when full), advance, or
// remove (cursor node unlinked, successor becomes cursor); advance and remove
// are no-ops on an empty list, and an unknown code only reports status. Every
// item gives one result: cursor value (zero if empty), empty flag, node count
// and refused flag. An item runs READ, EXEC, FIN and DONE when
// it needs a second memory step (insert into a non-empty list writes two
// links; advance and multi-node remove read the link, then the value RAM),
// and skips FIN otherwise; the chain of dependent registered RAM reads sets this.
// The result register frees the output side, so a new item is taken as soon
// as the previous result is loaded. No clearing pass is needed after reset.

module circular_list_with_cursor_unit
  import cllc_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IDX_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               req_type_i,
  input  logic signed [DATA_W-1:0] insert_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] cursor_value_o,
  output logic                     list_empty_o,
  output logic [CNT_W-1:0]         node_count_o,
  output logic                     refused_o
);

  state_e state_q, state_d;

  // Request capture
  logic [1:0]        req_q;
  logic [DATA_W-1:0] ins_val_q;

  // List state
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [IDX_W-1:0]  pred_q, pred_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] cur_val_q, cur_val_d;
  logic              refused_q, refused_d;

  // Result register
  logic              out_valid_q;
  logic [DATA_W-1:0] out_val_q;
  logic              out_empty_q;
  logic [CNT_W-1:0]  out_cnt_q;
  logic              out_refused_q;

  // Memory ports
  logic              val_we;
  logic [IDX_W-1:0]  val_waddr;
  logic [DATA_W-1:0] val_rdata;
  logic              link_we;
  logic [IDX_W-1:0]  link_waddr;
  logic [IDX_W-1:0]  link_wdata;
  logic [IDX_W-1:0]  link_rdata;

  free_ctrl_t        free_ctrl;
  logic [IDX_W-1:0]  alloc_idx;

  logic              list_full;
  logic              list_nil;
  logic              out_load;
  logic              in_accept;

  assign list_full = (cnt_q == CNT_W'(DEPTH));
  assign list_nil  = (cnt_q == '0);

  // Result slot is free when empty or being drained this cycle.
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == ST_IDLE) || out_load;
  assign in_accept  = in_valid_i && in_ready_o;

  // Link of the cursor is read continuously; its successor's value follows.
  cllc_ram #(
    .WIDTH (IDX_W),
    .DEPTH (DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (cur_q),
    .rdata_o (link_rdata)
  );

  cllc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (ins_val_q),
    .raddr_i (link_rdata),
    .rdata_o (val_rdata)
  );

  cllc_free_pool #(
    .DEPTH (DEPTH)
  ) u_free_pool (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (free_ctrl),
    .push_idx_i  (cur_q),
    .alloc_idx_o (alloc_idx)
  );

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    pred_d     = pred_q;
    cnt_d      = cnt_q;
    cur_val_d  = cur_val_q;
    refused_d  = refused_q;
    val_we     = 1'b0;
    val_waddr  = alloc_idx;
    link_we    = 1'b0;
    link_waddr = alloc_idx;
    link_wdata = link_rdata;
    free_ctrl  = '{pop: 1'b0, push: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_READ;
        end
      end

      // Link RAM read of the cursor is in flight.
      ST_READ: begin
        state_d   = ST_EXEC;
        refused_d = 1'b0;
      end

      ST_EXEC: begin
        state_d = ST_DONE;
        case (req_q)
          REQ_INSERT: begin
            if (list_full) begin
              refused_d = 1'b1;
            end else begin
              free_ctrl.pop = 1'b1;
              val_we        = 1'b1;
              link_we       = 1'b1;
              cur_d         = alloc_idx;
              cur_val_d     = ins_val_q;
              cnt_d         = cnt_q + CNT_W'(1);
              if (list_nil) begin
                // Lone node links to itself and is its own predecessor.
                link_wdata = alloc_idx;
                pred_d     = alloc_idx;
              end else begin
                // New node inherits the cursor's link; old cursor relinks in FIN.
                link_wdata = link_rdata;
                pred_d     = cur_q;
                state_d    = ST_FIN;
              end
            end
          end
          REQ_ADVANCE: begin
            if (!list_nil) begin
              pred_d  = cur_q;
              cur_d   = link_rdata;
              state_d = ST_FIN;
            end
          end
          REQ_REMOVE: begin
            if (cnt_q == CNT_W'(1)) begin
              free_ctrl.push = 1'b1;
              cnt_d          = '0;
            end else if (!list_nil) begin
              // Bypass the cursor node: predecessor takes its successor.
              free_ctrl.push = 1'b1;
              link_we        = 1'b1;
              link_waddr     = pred_q;
              link_wdata     = link_rdata;
              cur_d          = link_rdata;
              cnt_d          = cnt_q - CNT_W'(1);
              state_d        = ST_FIN;
            end
          end
          default: begin
          end
        endcase
      end

      ST_FIN: begin
        state_d = ST_DONE;
        if (req_q == REQ_INSERT) begin
          link_we    = 1'b1;
          link_waddr = pred_q;
          link_wdata = cur_q;
        end else begin
          cur_val_d = val_rdata;
        end
      end

      ST_DONE: begin
        if (out_load) begin
          state_d = in_accept ? ST_READ : ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_q     <= '0;
      pred_q    <= '0;
      cnt_q     <= '0;
      refused_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      pred_q    <= pred_d;
      cnt_q     <= cnt_d;
      refused_q <= refused_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    cur_val_q <= cur_val_d;
    if (in_accept) begin
      req_q     <= req_type_i;
      ins_val_q <= insert_value_i;
    end
    if (out_load) begin
      out_val_q     <= list_nil ? '0 : cur_val_q;
      out_empty_q   <= list_nil;
      out_cnt_q     <= cnt_q;
      out_refused_q <= refused_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cursor_value_o = out_val_q;
  assign list_empty_o   = out_empty_q;
  assign node_count_o   = out_cnt_q;
  assign refused_o      = out_refused_q;

endmodule

// File: rtl/core/cllc_checker.sv
`timescale 1ns / 1ps

module cllc_checker
  import cllc_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [DATA_W-1:0] cursor_value_o,
  input logic                     list_empty_o,
  input logic [CNT_W-1:0]         node_count_o,
  input logic                     refused_o
);

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cursor_value_o)
      && $stable(node_count_o) && $stable(refused_o))
    else $error("result changed while stalled");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (list_empty_o == (node_count_o == '0)))
    else $error("empty flag disagrees with count");

  a_empty_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && list_empty_o |-> cursor_value_o == '0)
    else $error("empty list reports nonzero value");

  a_refused_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && refused_o |-> node_count_o == CNT_W'(DEPTH))
    else $error("refused while entries free");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> node_count_o <= CNT_W'(DEPTH))
    else $error("count exceeds depth");

endmodule

bind circular_list_with_cursor_unit cllc_checker #(.DEPTH(DEPTH)) u_cllc_checker (.*);

// File: verif/tb_circular_list_with_cursor_unit.sv
`timescale 1ns / 1ps

module tb_circular_list_with_cursor_unit;
  import cllc_pkg::*;

  localparam int unsigned RING_DEPTH = 16;
  localparam int unsigned CNT_W      = 5;
  localparam logic [1:0]  REQ_NOP    = 2'd3;  // unknown code, reports status only

  // Status returned for every request.
  typedef struct packed {
    logic signed [DATA_W-1:0] cursor_value;
    logic                     list_empty;
    logic [CNT_W-1:0]         node_count;
    logic                     refused;
  } status_t;

  // One row of the directed sequence; a row may repeat, with the value
  // stepping up by one on each repeat.
  typedef struct packed {
    logic [1:0]        rq;
    logic [DATA_W-1:0] val;
    logic [7:0]        reps;
    logic              typed;
    status_t           want;
  } step_row_t;

  localparam status_t EMPTY_ST = '{32'sd0, 1'b1, 5'd0, 1'b0};
  localparam status_t NO_ST    = '{32'sd0, 1'b0, 5'd0, 1'b0};
  localparam int      N_ROWS   = 17;

  localparam step_row_t DIR_ROWS [N_ROWS] = '{
    // empty list: advance, remove and unknown code change nothing
    '{REQ_ADVANCE, 32'h0000_0000, 8'd1, 1'b1, EMPTY_ST},
    '{REQ_REMOVE,  32'h0000_0000, 8'd1, 1'b1, EMPTY_ST},
    '{REQ_NOP,     32'hFFFF_FFFF, 8'd1, 1'b1, EMPTY_ST},
    // first node links to itself; removing it empties the list again
    '{REQ_INSERT,  32'h7FFF_FFFF, 8'd1, 1'b1, '{32'sh7FFF_FFFF, 1'b0, 5'd1, 1'b0}},
    '{REQ_REMOVE,  32'h0000_0000, 8'd1, 1'b1, EMPTY_ST},
    '{REQ_INSERT,  32'h8000_0000, 8'd1, 1'b1, '{32'sh8000_0000, 1'b0, 5'd1, 1'b0}},
    '{REQ_INSERT,  32'hFFFF_FFFF, 8'd1, 1'b1, '{32'shFFFF_FFFF, 1'b0, 5'd2, 1'b0}},
    '{REQ_ADVANCE, 32'h0000_0000, 8'd1, 1'b0, NO_ST},
    '{REQ_NOP,     32'h0000_0000, 8'd1, 1'b0, NO_ST},
    '{REQ_REMOVE,  32'h0000_0000, 8'd1, 1'b0, NO_ST},
    // fill every entry, then a refused insert on the full list
    '{REQ_INSERT,  32'h1234_0000, 8'd15, 1'b0, NO_ST},
    '{REQ_INSERT,  32'h0000_0000, 8'd1, 1'b1, '{32'sh1234_000E, 1'b0, 5'd16, 1'b1}},
    '{REQ_ADVANCE, 32'h0000_0000, 8'd3, 1'b0, NO_ST},
    '{REQ_REMOVE,  32'h0000_0000, 8'd1, 1'b0, NO_ST},
    '{REQ_INSERT,  32'h5555_AAAA, 8'd1, 1'b0, NO_ST},
    // drain the whole list, then remove on empty once more
    '{REQ_REMOVE,  32'h0000_0000, 8'd16, 1'b0, NO_ST},
    '{REQ_REMOVE,  32'h0000_0000, 8'd1, 1'b1, EMPTY_ST}
  };

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               req_type_i     = REQ_NOP;
  logic signed [DATA_W-1:0] insert_value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i    = 1'b0;
  logic signed [DATA_W-1:0] cursor_value_o;
  logic                     list_empty_o;
  logic [CNT_W-1:0]         node_count_o;
  logic                     refused_o;

  // Shadow of the ring: values, links, spare-slot stack, cursor and its
  // predecessor.
  logic [DATA_W-1:0] ring_val  [RING_DEPTH];
  logic [3:0]        ring_next [RING_DEPTH];
  logic [3:0]        spare_slot[RING_DEPTH];
  logic [4:0]        spare_top;
  logic [3:0]        cur_slot;
  logic [3:0]        prev_slot;
  logic [CNT_W-1:0]  node_cnt;

  status_t pending_status[$];
  int      err_cnt   = 0;
  int      idle_pct  = 0;
  int      stall_pct = 0;
  int      hold_seq  = 0;

  circular_list_with_cursor_unit #(
    .DEPTH(RING_DEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .insert_value_i(insert_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cursor_value_o(cursor_value_o),
    .list_empty_o  (list_empty_o),
    .node_count_o  (node_count_o),
    .refused_o     (refused_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Apply one request to the shadow ring and return the status it reports.
  function automatic status_t apply_request(logic [1:0] rq, logic [DATA_W-1:0] v);
    status_t    st;
    logic [3:0] slot;
    st.refused = 1'b0;
    case (rq)
      REQ_INSERT: begin
        if (node_cnt == RING_DEPTH || spare_top == 0) begin
          st.refused = 1'b1;
        end else begin
          spare_top = spare_top - 5'd1;
          slot = spare_slot[spare_top[3:0]];
          ring_val[slot] = v;
          if (node_cnt == 0) begin
            ring_next[slot] = slot;
            prev_slot = slot;
          end else begin
            ring_next[slot] = ring_next[cur_slot];
            ring_next[cur_slot] = slot;
            prev_slot = cur_slot;
          end
          cur_slot = slot;
          node_cnt = node_cnt + CNT_W'(1);
        end
      end
      REQ_ADVANCE: begin
        if (node_cnt != 0) begin
          prev_slot = cur_slot;
          cur_slot = ring_next[cur_slot];
        end
      end
      REQ_REMOVE: begin
        if (node_cnt != 0) begin
          // Return the cursor slot to the spare stack.
          spare_slot[spare_top[3:0]] = cur_slot;
          spare_top = spare_top + 5'd1;
          if (node_cnt == 1) begin
            node_cnt = '0;
          end else begin
            ring_next[prev_slot] = ring_next[cur_slot];
            cur_slot = ring_next[prev_slot];
            node_cnt = node_cnt - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    st.cursor_value = (node_cnt != 0) ? ring_val[cur_slot] : '0;
    st.list_empty   = (node_cnt == 0);
    st.node_count   = node_cnt;
    return st;
  endfunction

  // Offer one item, hold it until accepted, then queue its expected status.
  task automatic send_item(input logic [1:0] rq, input logic [DATA_W-1:0] v,
                           input bit typed, input status_t want);
    int      gap;
    status_t st;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= rq;
    insert_value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    st = apply_request(rq, v);
    pending_status.push_back(typed ? want : st);
  endtask

  task automatic compare_field(input string fname, input logic [DATA_W-1:0] exp_v,
                               input logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Result side: check every accepted result, stall at random, and honor a
  // long hold-off when one is requested.
  initial begin
    status_t want;
    int      hold_left;
    int      hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_status.size() == 0) begin
          $display("%0t: result with nothing pending, actual value %0h count %0d",
                   $time, cursor_value_o, node_count_o);
          err_cnt++;
        end else begin
          want = pending_status.pop_front();
          compare_field("cursor_value", want.cursor_value, cursor_value_o);
          compare_field("list_empty", 32'(want.list_empty), 32'(list_empty_o));
          compare_field("node_count", 32'(want.node_count), 32'(node_count_o));
          compare_field("refused", 32'(want.refused), 32'(refused_o));
        end
      end
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Stimulus: directed rows first, then random requests in idling phases.
  initial begin
    logic [1:0]        rq;
    logic [DATA_W-1:0] v;
    int                bias;
    int                pick;
    int                wait_cnt;

    for (int i = 0; i < RING_DEPTH; i++) spare_slot[i] = 4'(i);
    spare_top = 5'(RING_DEPTH);
    cur_slot  = '0;
    prev_slot = '0;
    node_cnt  = '0;
    bias      = 50;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[r]) begin
      for (int k = 0; k < int'(DIR_ROWS[r].reps); k++) begin
        send_item(DIR_ROWS[r].rq, DIR_ROWS[r].val + DATA_W'(k), DIR_ROWS[r].typed,
                  DIR_ROWS[r].want);
      end
    end

    for (int n = 0; n < 1850; n++) begin
      // Switch the idling phase every 370 items.
      if (n % 370 == 0) begin
        case (n / 370)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 85; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 85; end
          3: begin idle_pct = 13; stall_pct = 13; end
          default: begin idle_pct = 0; stall_pct = 0; end
        endcase
      end
      // Last phase: long receiver hold-offs so the block backs up.
      if (n >= 1480 && n % 100 == 0) hold_seq++;
      // Drift the list toward full, half or empty so both ends get hit.
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: bias = 85;
          1: bias = 50;
          default: bias = 15;
        endcase
      end

      if ($urandom_range(0, 99) < 3) begin
        rq = REQ_NOP;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < bias) rq = REQ_INSERT;
        else if (pick < bias + (100 - bias) / 2) rq = REQ_ADVANCE;
        else rq = REQ_REMOVE;
      end

      case ($urandom_range(0, 9))
        0: v = 32'h7FFF_FFFF;
        1: v = 32'h8000_0000;
        2: v = DATA_W'($urandom_range(0, 15));
        default: v = $urandom;
      endcase
      send_item(rq, v, 1'b0, NO_ST);
    end

    in_valid_i <= 1'b0;
    stall_pct = 0;
    wait_cnt  = 0;
    while (pending_status.size() != 0 && wait_cnt < 5000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    if (pending_status.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_status.size());
      err_cnt++;
    end
    // Catch any stray result after the last expected one.
    repeat (12) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
